@@ hdl/tbsf_pkg.sv @@
// Shared types, constants and helpers for the token budget sequence forcer.
`default_nettype none
package tbsf_pkg;

	localparam int MAX_SEQ    = 4;   // longest usable sequence
	localparam int TOKEN_BITS = 32;  // token bits that take part in compares
	localparam int SEQ_SLOTS  = 4;   // token slots per sequence in the register map
	localparam int BUDGET_W   = 20;
	localparam int POS_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int TOK_W      = 32;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_COUNT = 2'd1,
		PH_FORCE = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	localparam logic [1:0] MODE_TOKEN = 2'd0;
	localparam logic [1:0] MODE_CHECK = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BUDGET   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTHS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_A  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_B  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_END_A    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END_B    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FORCED_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FORCED_B = 3'd7;

	typedef logic [SEQ_SLOTS-1:0][TOKEN_BITS-1:0] seq_tok_t;

	typedef struct packed {
		logic [BUDGET_W-1:0] budget;
		logic [POS_W-1:0]    start_len;
		logic [POS_W-1:0]    end_len;
		logic [POS_W-1:0]    forced_len;
		phase_t              init_phase;
		seq_tok_t            start_tok;
		seq_tok_t            end_tok;
		seq_tok_t            forced_tok;
		logic                reinit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]          phase;
		logic                keep;
		logic [TOK_W-1:0]    forced_token;
		logic [BUDGET_W-1:0] remaining;
	} res_t;

	function automatic logic [POS_W-1:0] clamp_len(input logic [POS_W-1:0] n);
		return (n > POS_W'(MAX_SEQ)) ? POS_W'(MAX_SEQ) : n;
	endfunction

	function automatic logic [TOK_W-1:0] sext_token(input logic [TOKEN_BITS-1:0] t);
		logic signed [TOKEN_BITS-1:0] s;
		s = signed'(t);
		return TOK_W'(s);
	endfunction

endpackage
`default_nettype wire

@@ hdl/tbsf_if.sv @@
// Request, result and configuration channel interfaces.
`default_nettype none
interface tbsf_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic signed [31:0] token;
	modport source (output valid, mode, token, input ready);
	modport sink   (input valid, mode, token, output ready);
endinterface

interface tbsf_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  phase;
	logic        keep;
	logic signed [31:0] forced_token;
	logic [19:0] remaining;
	modport source (output valid, phase, keep, forced_token, remaining, input ready);
	modport sink   (input valid, phase, keep, forced_token, remaining, output ready);
endinterface

interface tbsf_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/tbsf_regs.sv @@
// Configuration register file and decoded sequence settings.
`default_nettype none
module tbsf_regs (
	input  logic              clk,
	input  logic              arst_n,
	tbsf_cfg_if.sink          cfg,
	output tbsf_pkg::cfg_t    cfg_o
);
	logic [tbsf_pkg::BUDGET_W-1:0]   budget_q;
	logic [10:0]                     lengths_q;
	logic [5:0][tbsf_pkg::CFG_DATA_W-1:0] seq_q;
	logic                            reinit_q;
	logic                            wr;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid & cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q  <= '0;
			lengths_q <= '0;
			seq_q     <= '0;
			reinit_q  <= 1'b0;
		end else begin
			reinit_q <= wr;
			if (wr) begin
				unique case (cfg.index)
					tbsf_pkg::REG_BUDGET:   budget_q  <= cfg.data[tbsf_pkg::BUDGET_W-1:0];
					tbsf_pkg::REG_LENGTHS:  lengths_q <= cfg.data[10:0];
					tbsf_pkg::REG_START_A:  seq_q[0]  <= cfg.data;
					tbsf_pkg::REG_START_B:  seq_q[1]  <= cfg.data;
					tbsf_pkg::REG_END_A:    seq_q[2]  <= cfg.data;
					tbsf_pkg::REG_END_B:    seq_q[3]  <= cfg.data;
					tbsf_pkg::REG_FORCED_A: seq_q[4]  <= cfg.data;
					tbsf_pkg::REG_FORCED_B: seq_q[5]  <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	// token k of a sequence: register k[1], half k[0]
	always_comb begin
		cfg_o.budget     = budget_q;
		cfg_o.start_len  = tbsf_pkg::clamp_len(lengths_q[2:0]);
		cfg_o.end_len    = tbsf_pkg::clamp_len(lengths_q[5:3]);
		cfg_o.forced_len = tbsf_pkg::clamp_len(lengths_q[8:6]);
		cfg_o.init_phase = tbsf_pkg::phase_t'(lengths_q[10:9]);
		cfg_o.reinit     = reinit_q;
		for (int k = 0; k < tbsf_pkg::SEQ_SLOTS; k++) begin
			cfg_o.start_tok[k]  = seq_q[0 + k/2][(k%2)*32 +: tbsf_pkg::TOKEN_BITS];
			cfg_o.end_tok[k]    = seq_q[2 + k/2][(k%2)*32 +: tbsf_pkg::TOKEN_BITS];
			cfg_o.forced_tok[k] = seq_q[4 + k/2][(k%2)*32 +: tbsf_pkg::TOKEN_BITS];
		end
	end
endmodule
`default_nettype wire

@@ hdl/tbsf_match.sv @@
// Sequence matcher step; on a mismatch it falls back only to the first token.
`default_nettype none
module tbsf_match (
	input  logic [tbsf_pkg::POS_W-1:0]      len,
	input  tbsf_pkg::seq_tok_t              seq,
	input  logic [tbsf_pkg::POS_W-1:0]      pos,
	input  logic [tbsf_pkg::TOKEN_BITS-1:0] tok,
	output logic [tbsf_pkg::POS_W-1:0]      pos_n,
	output logic                            hit
);
	logic [tbsf_pkg::POS_W-1:0] p;
	logic [tbsf_pkg::POS_W-1:0] p_inc;

	always_comb begin
		p     = (pos >= len) ? '0 : pos;
		p_inc = p + 1'b1;
		hit   = 1'b0;
		pos_n = pos;
		if (len != '0) begin
			if (tok == seq[p[1:0]]) begin
				if (p_inc >= len) begin
					pos_n = '0;
					hit   = 1'b1;
				end else begin
					pos_n = p_inc;
				end
			end else begin
				pos_n = (tok == seq[0]) ? tbsf_pkg::POS_W'(1) : '0;
			end
		end
	end
endmodule
`default_nettype wire

@@ hdl/tbsf_core.sv @@
// Phase state, budget counter and per-item result logic.
`default_nettype none
module tbsf_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tbsf_pkg::cfg_t            cfg,
	input  logic                      advance,
	input  logic [1:0]                mode,
	input  logic [tbsf_pkg::TOK_W-1:0] token,
	output tbsf_pkg::res_t            res
);
	tbsf_pkg::phase_t                 phase_q, phase_n;
	logic [tbsf_pkg::BUDGET_W-1:0]    left_q, left_n, left_dec;
	logic [tbsf_pkg::POS_W-1:0]       spos_q, spos_n, epos_q, epos_n;
	logic [tbsf_pkg::POS_W-1:0]       fidx_q, fidx_n, fidx_inc;
	logic [tbsf_pkg::POS_W-1:0]       sm_pos, em_pos;
	logic                             sm_hit, em_hit;
	logic [tbsf_pkg::TOKEN_BITS-1:0]  tok;
	logic                             pend_cur, pend_n;
	tbsf_pkg::phase_t                 init_phase;

	assign tok = token[tbsf_pkg::TOKEN_BITS-1:0];

	tbsf_match u_start (
		.len(cfg.start_len), .seq(cfg.start_tok), .pos(spos_q), .tok(tok),
		.pos_n(sm_pos), .hit(sm_hit)
	);

	tbsf_match u_end (
		.len(cfg.end_len), .seq(cfg.end_tok), .pos(epos_q), .tok(tok),
		.pos_n(em_pos), .hit(em_hit)
	);

	assign init_phase = (cfg.init_phase == tbsf_pkg::PH_COUNT && cfg.budget == '0)
		? tbsf_pkg::PH_FORCE : cfg.init_phase;

	// next state
	always_comb begin
		phase_n  = phase_q;
		left_n   = left_q;
		spos_n   = spos_q;
		epos_n   = epos_q;
		fidx_n   = fidx_q;
		left_dec = (left_q != '0) ? left_q - 1'b1 : '0;
		fidx_inc = (fidx_q != '1) ? fidx_q + 1'b1 : fidx_q;
		unique case (mode)
			tbsf_pkg::MODE_TOKEN: begin
				unique case (phase_q)
					tbsf_pkg::PH_IDLE, tbsf_pkg::PH_DONE: begin
						spos_n = sm_pos;
						if (sm_hit) begin
							left_n  = cfg.budget;
							phase_n = (cfg.budget == '0) ? tbsf_pkg::PH_FORCE
								: tbsf_pkg::PH_COUNT;
							epos_n  = '0;
							fidx_n  = '0;
						end
					end
					tbsf_pkg::PH_COUNT: begin
						epos_n = em_pos;
						if (em_hit) begin
							phase_n = tbsf_pkg::PH_DONE;
						end else begin
							left_n = left_dec;
							if (left_dec == '0) begin
								phase_n = tbsf_pkg::PH_FORCE;
								epos_n  = '0;
								fidx_n  = '0;
							end
						end
					end
					tbsf_pkg::PH_FORCE: begin
						fidx_n = fidx_inc;
						if (fidx_inc >= cfg.forced_len)
							phase_n = tbsf_pkg::PH_DONE;
					end
					default: ;
				endcase
			end
			tbsf_pkg::MODE_CLEAR: begin
				phase_n = tbsf_pkg::PH_IDLE;
				left_n  = cfg.budget;
				spos_n  = '0;
				epos_n  = '0;
				fidx_n  = '0;
			end
			default: ;
		endcase
	end

	// result
	always_comb begin
		pend_cur = (phase_q == tbsf_pkg::PH_FORCE) && (fidx_q < cfg.forced_len);
		pend_n   = (phase_n == tbsf_pkg::PH_FORCE) && (fidx_n < cfg.forced_len);
		res.phase     = phase_n;
		res.remaining = left_n;
		res.keep      = !((mode == tbsf_pkg::MODE_CHECK) && pend_cur &&
			(tok != cfg.forced_tok[fidx_q[1:0]]));
		res.forced_token = pend_n ? tbsf_pkg::sext_token(cfg.forced_tok[fidx_n[1:0]]) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tbsf_pkg::PH_IDLE;
			left_q  <= '0;
			spos_q  <= '0;
			epos_q  <= '0;
			fidx_q  <= '0;
		end else if (cfg.reinit) begin
			phase_q <= init_phase;
			left_q  <= cfg.budget;
			spos_q  <= '0;
			epos_q  <= '0;
			fidx_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			left_q  <= left_n;
			spos_q  <= spos_n;
			epos_q  <= epos_n;
			fidx_q  <= fidx_n;
		end
	end
endmodule
`default_nettype wire

@@ hdl/token_budget_sequence_forcer.sv @@
// Top level of the token budget sequence forcer.
`default_nettype none
// Watches accepted token ids and steps through idle, counting, forcing and done.
// Every request (accepted token, candidate check or return to idle) gives exactly
// one result carrying the phase after the step, the keep flag, the token being
// forced and the budget left. One request is taken every clock cycle unless a
// stalled result blocks intake; a single pass of sequence compares and the
// budget decrement lies between the input register and the result register.
// A taken request waits in the input register until the result slot is free,
// then its result is loaded into the result register and shown on the output.
// The result register holds a finished result while the next request is already
// in the input register, so a stalled result only blocks intake once both are full.
// A configuration write takes effect on the following cycle by re-initializing
// the phase state from the new register values. Writes are always ready; the user
// must only issue them with no request outstanding; the block does not enforce it.
module token_budget_sequence_forcer (
	input  logic       clk,
	input  logic       arst_n,
	tbsf_req_if.sink   req,
	tbsf_rsp_if.source rsp,
	tbsf_cfg_if.sink   cfg
);
	tbsf_pkg::cfg_t          cfg_w;
	tbsf_pkg::res_t          res_w, res_q;
	logic                    valid_s1;
	logic [1:0]              mode_s1;
	logic [tbsf_pkg::TOK_W-1:0] token_s1;
	logic                    rsp_valid_q;
	logic                    advance;

	tbsf_regs u_regs (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .cfg_o(cfg_w)
	);

	// request in the input register moves on when the result slot frees up
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			mode_s1  <= req.mode;
			token_s1 <= req.token;
		end
	end

	tbsf_core u_core (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_w), .advance(advance),
		.mode(mode_s1), .token(token_s1), .res(res_w)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_w;
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.phase        = res_q.phase;
	assign rsp.keep         = res_q.keep;
	assign rsp.forced_token = res_q.forced_token;
	assign rsp.remaining    = res_q.remaining;
endmodule
`default_nettype wire

@@ hdl/tbsf_chk.sv @@
// Port-level checker for the token budget sequence forcer, with its bind.
`default_nettype none
module tbsf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_phase,
	input logic        rsp_keep,
	input logic [31:0] rsp_forced_token,
	input logic [19:0] rsp_remaining
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase) &&
		$stable(rsp_keep) && $stable(rsp_forced_token) && $stable(rsp_remaining))
		else $error("result changed while stalled");

	a_intake: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request intake blocked without a stalled result");

	a_forced_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_forced_token != '0 |-> rsp_phase == 2'(tbsf_pkg::PH_FORCE))
		else $error("forced token outside forcing phase");

	a_mask_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_keep |-> rsp_phase == 2'(tbsf_pkg::PH_FORCE))
		else $error("candidate masked outside forcing phase");
endmodule

bind token_budget_sequence_forcer tbsf_chk u_tbsf_chk (
	.clk(clk),
	.arst_n(arst_n),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_phase(rsp.phase),
	.rsp_keep(rsp.keep),
	.rsp_forced_token(rsp.forced_token),
	.rsp_remaining(rsp.remaining)
);
`default_nettype wire

@@ bench/tbsf_tb_pkg.sv @@
// Result tracker for the token budget sequence forcer bench: predicts and checks results.
`timescale 1ns / 1ps
package tbsf_tb_pkg;
	import tbsf_pkg::*;

	// mode code the block leaves unused; it must report state and change nothing
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// sequence selectors; each length field sits at 3 * selector in lengths_reg
	localparam int unsigned SEQ_START  = 0;
	localparam int unsigned SEQ_END    = 1;
	localparam int unsigned SEQ_FORCED = 2;

	class forcer_tracker;
		logic [BUDGET_W-1:0] budget_reg;
		logic [10:0]         lengths_reg;
		logic [63:0]         seq_reg [6];

		phase_t              phase;
		logic [BUDGET_W-1:0] left;
		int unsigned         start_pos;
		int unsigned         end_pos;
		int unsigned         forced_pos;

		res_t                awaited_results [$];
		int unsigned         mismatches;

		function new();
			budget_reg  = '0;
			lengths_reg = '0;
			foreach (seq_reg[i]) seq_reg[i] = '0;
			mismatches  = 0;
			restart();
		endfunction

		// usable length of a sequence, long fields clamp to MAX_SEQ
		function int unsigned len_of(int unsigned which);
			int unsigned n;
			n = (lengths_reg >> (which * 3)) & 11'h7;
			return (n > MAX_SEQ) ? MAX_SEQ : n;
		endfunction

		function logic [31:0] slot(int unsigned which, int unsigned k);
			logic [63:0] w;
			w = seq_reg[which * 2 + ((k >> 1) & 1)];
			return (k & 1) ? w[63:32] : w[31:0];
		endfunction

		function void restart();
			phase = phase_t'(lengths_reg[10:9]);
			left  = budget_reg;
			if (phase == PH_COUNT && left == 0) phase = PH_FORCE;
			start_pos  = 0;
			end_pos    = 0;
			forced_pos = 0;
		endfunction

		// matcher step; on a miss it falls back to the first token only
		function bit advance(int unsigned which, inout int unsigned pos, input logic [31:0] tok);
			int unsigned len;
			int unsigned p;
			len = len_of(which);
			p   = pos;
			if (len == 0) return 1'b0;
			if (p >= len) p = 0;
			if (tok == slot(which, p & 3)) begin
				p++;
				if (p >= len) begin
					pos = 0;
					return 1'b1;
				end
				pos = p;
				return 1'b0;
			end
			pos = (tok == slot(which, 0)) ? 1 : 0;
			return 1'b0;
		endfunction

		function bit forcing_pending();
			return phase == PH_FORCE && forced_pos < len_of(SEQ_FORCED);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
			case (idx)
				REG_BUDGET: budget_reg = value[BUDGET_W-1:0];
				REG_LENGTHS: lengths_reg = value[10:0];
				default: seq_reg[idx - REG_START_A] = value;
			endcase
			restart();
		endfunction

		function void note_request(logic [1:0] mode, logic [31:0] tok);
			res_t r;
			r.keep         = 1'b1;
			r.forced_token = '0;
			case (mode)
				MODE_TOKEN: begin
					if (phase == PH_IDLE || phase == PH_DONE) begin
						if (advance(SEQ_START, start_pos, tok)) begin
							left       = budget_reg;
							phase      = (left == 0) ? PH_FORCE : PH_COUNT;
							end_pos    = 0;
							forced_pos = 0;
						end
					end else if (phase == PH_COUNT) begin
						if (advance(SEQ_END, end_pos, tok)) begin
							phase = PH_DONE;
						end else begin
							if (left != 0) left--;
							if (left == 0) begin
								phase      = PH_FORCE;
								end_pos    = 0;
								forced_pos = 0;
							end
						end
					end else begin
						if (forced_pos < 7) forced_pos++;
						if (forced_pos >= len_of(SEQ_FORCED)) phase = PH_DONE;
					end
				end
				MODE_CHECK: begin
					if (forcing_pending() && tok != slot(SEQ_FORCED, forced_pos & 3))
						r.keep = 1'b0;
				end
				MODE_CLEAR: begin
					phase      = PH_IDLE;
					left       = budget_reg;
					start_pos  = 0;
					end_pos    = 0;
					forced_pos = 0;
				end
				default: ;
			endcase
			if (forcing_pending()) r.forced_token = slot(SEQ_FORCED, forced_pos & 3);
			r.phase     = phase;
			r.remaining = left;
			awaited_results.push_back(r);
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (awaited_results.size() == 0) begin
				$error("result with none awaited: phase %0d keep %0d forced_token %0h remaining %0d",
					got.phase, got.keep, got.forced_token, got.remaining);
				mismatches++;
				return;
			end
			want = awaited_results.pop_front();
			field_check("phase", want.phase, got.phase);
			field_check("keep", want.keep, got.keep);
			field_check("forced_token", want.forced_token, got.forced_token);
			field_check("remaining", want.remaining, got.remaining);
		endfunction
	endclass

endpackage

@@ bench/tb_top.sv @@
// Top-level bench for the token budget sequence forcer: stimulus, handshakes and checks.
`timescale 1ns / 1ps
module tb_top;
	import tbsf_pkg::*;
	import tbsf_tb_pkg::*;

	// cycles with no handshake of any kind before the run is declared hung
	localparam int QUIET_LIMIT  = 2000;
	// extra cycles after the last result: two-stage pipe plus margin
	localparam int DRAIN_CYCLES = 6;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 48;

	logic clk;
	logic arst_n;

	tbsf_req_if req_ch ();
	tbsf_rsp_if rsp_ch ();
	tbsf_cfg_if cfg_ch ();

	token_budget_sequence_forcer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	forcer_tracker tracker;
	logic [63:0]   seq_words [6];   // staged sequence registers for the next setting
	bit            calm;            // set: neither side idles
	int unsigned   items_sent;
	int unsigned   quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sink side: drop ready about 18% of cycles unless in a calm stretch.
	always @(negedge clk) begin
		rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 18);
	end

	// Monitor: results are checked before the request of the same edge is
	// noted; a result can never belong to a request taken at the same edge.
	always @(posedge clk) begin : monitor
		res_t got;
		bit   moved;
		moved = 1'b0;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{phase: rsp_ch.phase, keep: rsp_ch.keep,
					forced_token: rsp_ch.forced_token, remaining: rsp_ch.remaining};
				tracker.check_result(got);
				moved = 1'b1;
			end
			if (req_ch.valid && req_ch.ready) begin
				tracker.note_request(req_ch.mode, req_ch.token);
				moved = 1'b1;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				tracker.write_reg(cfg_ch.index, cfg_ch.data);
				moved = 1'b1;
			end
		end
		quiet = moved ? 0 : quiet + 1;
	end

	initial begin : watchdog
		wait (quiet >= QUIET_LIMIT);
		$display("tb_top: errors");
		$finish;
	end

	// One request; random idle cycles ahead of it, then hold until taken.
	task automatic send_request(input logic [1:0] mode, input logic [31:0] tok);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 18) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode  <= mode;
		req_ch.token <= tok;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	// Block goes idle only once every awaited result is back, plus pipe margin.
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (tracker.awaited_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes every register; ignored upper data bits get random fill.
	task automatic program_regs(input logic [BUDGET_W-1:0] budget, input logic [10:0] lengths);
		settle();
		write_reg(REG_BUDGET, {$urandom(), 12'($urandom()), budget});
		write_reg(REG_LENGTHS, {$urandom(), 21'($urandom()), lengths});
		write_reg(REG_START_A, seq_words[0]);
		write_reg(REG_START_B, seq_words[1]);
		write_reg(REG_END_A, seq_words[2]);
		write_reg(REG_END_B, seq_words[3]);
		write_reg(REG_FORCED_A, seq_words[4]);
		write_reg(REG_FORCED_B, seq_words[5]);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [2:0] pick_len();
		return ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
	endfunction

	// flavor 0: huge budget, clamped lengths, start in counting
	// flavor 1: zero budget, empty sequences, start in done
	// otherwise: mostly small budgets and short sequences
	task automatic random_setting(input int unsigned flavor);
		logic [31:0]         t [4];
		logic [BUDGET_W-1:0] budget;
		logic [10:0]         lengths;
		for (int s = 0; s < 3; s++) begin
			t[0] = $urandom();
			for (int k = 1; k < 4; k++)
				t[k] = ($urandom_range(0, 99) < 30) ? t[0] : $urandom();   // repeats hit fallback
			seq_words[2 * s]     = {t[1], t[0]};
			seq_words[2 * s + 1] = {t[3], t[2]};
		end
		case (flavor)
			0: begin
				budget  = '1;
				lengths = {PH_COUNT, 3'd7, 3'd7, 3'd7};
			end
			1: begin
				budget  = '0;
				lengths = {PH_DONE, 3'd0, 3'd0, 3'd0};
			end
			default: begin
				case ($urandom_range(0, 9))
					0, 1, 2: budget = '0;
					3: budget = '1;
					default: budget = BUDGET_W'($urandom_range(1, 8));
				endcase
				lengths = {2'($urandom_range(0, 3)), pick_len(), pick_len(), pick_len()};
			end
		endcase
		program_regs(budget, lengths);
	endtask

	// token ids: extremes, configured sequence tokens, or anything
	function automatic logic [31:0] pick_token();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4, 5: return tracker.slot($urandom_range(0, 2), $urandom_range(0, 3));
			default: return $urandom();
		endcase
	endfunction

	// Feed a whole configured sequence, or a prefix cut by a stray token.
	task automatic feed_sequence(input int unsigned which, input bit broken);
		int unsigned n;
		int unsigned stop;
		n = tracker.len_of(which);
		if (n == 0) begin
			send_request(MODE_TOKEN, $urandom());
			return;
		end
		stop = broken ? $urandom_range(0, n - 1) : n;
		for (int k = 0; k < stop; k++) send_request(MODE_TOKEN, tracker.slot(which, k));
		if (broken) send_request(MODE_TOKEN, pick_token());
	endtask

	// Mostly well-formed start/end sequences and forced-token checks,
	// some noise, clears and unused-mode requests.
	task automatic random_burst();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			feed_sequence(SEQ_START, 1'b0);
		end else if (r < 45) begin
			feed_sequence(SEQ_START, 1'b1);
		end else if (r < 58) begin
			feed_sequence(SEQ_END, $urandom_range(0, 4) == 0);
		end else if (r < 72) begin
			send_request(MODE_CHECK, $urandom_range(0, 1) ?
				tracker.slot(SEQ_FORCED, $urandom_range(0, 3)) : pick_token());
		end else if (r < 86) begin
			send_request(MODE_TOKEN, pick_token());
		end else if (r < 93) begin
			// run of plain tokens: drains small budgets and walks forcing
			repeat ($urandom_range(2, 6)) send_request(MODE_TOKEN, $urandom());
		end else if (r < 97) begin
			send_request(MODE_CLEAR, $urandom());
		end else begin
			send_request(MODE_SPARE, $urandom());
		end
	endtask

	initial begin : stimulus
		int unsigned phase_end;
		tracker      = new();
		calm         = 1'b0;
		items_sent   = 0;
		quiet        = 0;
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode  = MODE_TOKEN;
		req_ch.token = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_BUDGET;
		cfg_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, setting A: budget 2, start/end length 2, forced length 3.
		seq_words[0] = {32'h7fff_ffff, 32'h8000_0000};
		seq_words[1] = '0;
		seq_words[2] = {32'h0000_0000, 32'hffff_ffff};
		seq_words[3] = '0;
		seq_words[4] = {32'hffff_fffb, 32'h0000_0005};
		seq_words[5] = {32'h0000_0009, 32'h1234_5678};
		program_regs(20'd2, {PH_IDLE, 3'd3, 3'd2, 3'd2});
		send_request(MODE_SPARE, 32'hdead_beef);      // unused mode: report only
		send_request(MODE_CHECK, 32'h0000_0007);      // idle: nothing masked
		send_request(MODE_TOKEN, 32'h8000_0000);
		send_request(MODE_TOKEN, 32'h8000_0000);      // mismatch falls back to first token
		send_request(MODE_TOKEN, 32'h7fff_ffff);      // start matched, counting
		send_request(MODE_TOKEN, 32'hffff_ffff);      // end prefix, budget still counts
		send_request(MODE_TOKEN, 32'h0000_0000);      // end matched before budget ran out
		send_request(MODE_CLEAR, 32'h0000_0000);
		send_request(MODE_TOKEN, 32'h8000_0000);
		send_request(MODE_TOKEN, 32'h7fff_ffff);
		send_request(MODE_TOKEN, 32'h0000_0003);
		send_request(MODE_TOKEN, 32'h0000_0003);      // budget spent, forcing
		send_request(MODE_CHECK, 32'h0000_0005);      // the forced token survives
		send_request(MODE_CHECK, 32'h0000_0006);      // anything else is masked
		send_request(MODE_TOKEN, 32'h0000_0006);
		send_request(MODE_CHECK, 32'hffff_fffb);      // negative forced token
		send_request(MODE_TOKEN, 32'h0000_0000);
		send_request(MODE_TOKEN, 32'h0000_0000);      // forced sequence ends, done

		// Directed, setting B: zero budget with counting as initial phase,
		// start length field above the max, empty end and forced sequences.
		seq_words[0] = {32'hffff_fffe, 32'h0000_0001};
		seq_words[1] = {32'haaaa_aaaa, 32'h5555_5555};
		program_regs(20'd0, {PH_COUNT, 3'd0, 3'd0, 3'd7});
		send_request(MODE_CHECK, 32'h0000_1234);      // forcing, empty sequence masks nothing
		send_request(MODE_TOKEN, 32'h0000_0000);      // next token ends it
		feed_sequence(SEQ_START, 1'b0);              // four tokens, zero budget: forcing
		send_request(MODE_TOKEN, 32'h0000_0000);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			calm = (p == 4) || (p == 5);
			random_setting(p);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) random_burst();
		end
		calm = 1'b0;
		settle();

		if (tracker.mismatches == 0 && tracker.awaited_results.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
